@@ rtl/tpc_pkg.sv @@
package tpc_pkg;

  // Fixed field widths of the channels
  localparam int unsigned LETTER_W       = 5;
  localparam int unsigned PREFIX_COUNT_W = 20;

  // Defaults for the top-level parameters
  localparam int unsigned NODE_POOL_DEF  = 4096;
  localparam int unsigned ALPHABET_DEF   = 26;
  localparam int unsigned COUNT_BITS_DEF = 20;

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Result status codes
  localparam logic STATUS_DONE      = 1'b0;
  localparam logic STATUS_POOL_FULL = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } tpc_state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;  // write a zero row at the sweep address
    logic accept;      // capture the input beat and read the cursor row
    logic exec;        // apply the letter, write back, update the cursor
  } tpc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // sweep is at the last row
    logic item_last;   // captured letter ends its word
    logic out_busy;    // result register full and not drained this cycle
  } tpc_status_t;

endpackage

@@ rtl/tpc_item_if.sv @@
interface tpc_item_if import tpc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [LETTER_W-1:0] letter;
  logic                last;

  modport source (output valid, kind, letter, last, input ready);
  modport sink   (input valid, kind, letter, last, output ready);
endinterface

@@ rtl/tpc_result_if.sv @@
interface tpc_result_if import tpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [PREFIX_COUNT_W-1:0] prefix_count;
  logic                      status;

  modport source (output valid, prefix_count, status, input ready);
  modport sink   (input valid, prefix_count, status, output ready);
endinterface

@@ rtl/tpc_ctrl.sv @@
module tpc_ctrl import tpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tpc_status_t status_i,
  output tpc_cmd_t    cmd_o
);

  tpc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        // a word end waits for room in the result register
        if (!status_i.item_last || !status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o.clear_step = 1'b0;
    cmd_o.accept     = 1'b0;
    cmd_o.exec       = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = !status_i.item_last || !status_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_CLEAR |=> state_q != ST_CLEAR)
    else $error("sweep state re-entered after it finished");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ST_EXEC)
    else $error("accepted beat not followed by execution");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear_step |-> !cmd_o.accept && !cmd_o.exec)
    else $error("item work during the sweep");

endmodule

@@ rtl/tpc_datapath.sv @@
module tpc_datapath import tpc_pkg::*; #(
  parameter int unsigned NODE_POOL  = NODE_POOL_DEF,
  parameter int unsigned ALPHABET   = ALPHABET_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tpc_cmd_t                  cmd_i,
  output tpc_status_t               status_o,
  input  logic                      kind_i,
  input  logic [LETTER_W-1:0]       letter_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [PREFIX_COUNT_W-1:0] prefix_count_o,
  output logic                      res_status_o
);

  localparam int unsigned NodeW  = $clog2(NODE_POOL);
  localparam int unsigned UsedW  = $clog2(NODE_POOL + 1);
  localparam int unsigned IdxW   = $clog2(ALPHABET);
  localparam int unsigned EntryW = NodeW + COUNT_BITS;
  localparam int unsigned RowW   = ALPHABET * EntryW;

  // One row per node: for each letter the child link and that child's count.
  logic [RowW-1:0] row_mem [NODE_POOL];
  logic [RowW-1:0] rd_row_q;

  logic                  mem_we;
  logic [NodeW-1:0]      mem_waddr;
  logic [RowW-1:0]       mem_wdata;
  logic [RowW-1:0]       upd_row;

  logic [NodeW-1:0]      clr_cnt_q;
  logic [NodeW-1:0]      cursor_q;
  logic                  stopped_q;
  logic [UsedW-1:0]      used_q;
  logic [COUNT_BITS-1:0] cur_count_q;

  logic                  kind_q;
  logic [LETTER_W-1:0]   letter_q;
  logic                  last_q;

  logic                      out_valid_q;
  logic [PREFIX_COUNT_W-1:0] prefix_count_q;
  logic                      status_q;

  logic                  in_range;
  logic [IdxW-1:0]       idx;
  logic [EntryW-1:0]     sel_entry;
  logic [NodeW-1:0]      sel_link;
  logic [COUNT_BITS-1:0] sel_count;
  logic [COUNT_BITS-1:0] bump_count;
  logic                  pool_free;

  logic                  stop_n;
  logic [NodeW-1:0]      cursor_n;
  logic [COUNT_BITS-1:0] count_n;
  logic                  wr_n;
  logic                  alloc_n;
  logic [EntryW-1:0]     entry_n;

  assign in_range   = 9'(letter_q) < 9'(ALPHABET);
  assign idx        = IdxW'(letter_q);
  assign sel_entry  = rd_row_q[idx*EntryW +: EntryW];
  assign sel_link   = sel_entry[NodeW-1:0];
  assign sel_count  = sel_entry[EntryW-1:NodeW];
  assign bump_count = (sel_count == '1) ? sel_count : sel_count + COUNT_BITS'(1);
  assign pool_free  = used_q < UsedW'(NODE_POOL);

  // Link value zero means no child; the root is never a child.
  always_comb begin
    stop_n   = stopped_q;
    cursor_n = cursor_q;
    count_n  = cur_count_q;
    wr_n     = 1'b0;
    alloc_n  = 1'b0;
    entry_n  = sel_entry;
    if (!stopped_q) begin
      if (!in_range) begin
        stop_n = 1'b1;
      end else if (kind_q == KIND_QUERY) begin
        if (sel_link == '0) begin
          stop_n = 1'b1;
        end else begin
          cursor_n = sel_link;
          count_n  = sel_count;
        end
      end else if (sel_link != '0) begin
        wr_n     = 1'b1;
        entry_n  = {bump_count, sel_link};
        cursor_n = sel_link;
        count_n  = bump_count;
      end else if (pool_free) begin
        wr_n     = 1'b1;
        alloc_n  = 1'b1;
        entry_n  = {COUNT_BITS'(1), used_q[NodeW-1:0]};
        cursor_n = used_q[NodeW-1:0];
        count_n  = COUNT_BITS'(1);
      end else begin
        stop_n = 1'b1;
      end
    end
  end

  always_comb begin
    upd_row = rd_row_q;
    upd_row[idx*EntryW +: EntryW] = entry_n;
  end

  assign mem_we    = cmd_i.clear_step || (cmd_i.exec && wr_n);
  assign mem_waddr = cmd_i.clear_step ? clr_cnt_q : cursor_q;
  assign mem_wdata = cmd_i.clear_step ? '0 : upd_row;

  always_ff @(posedge clk_i) begin
    if (mem_we) row_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) rd_row_q <= row_mem[cursor_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q   <= kind_i;
      letter_q <= letter_i;
      last_q   <= last_i;
    end
    if (cmd_i.exec) cur_count_q <= count_n;
    if (cmd_i.exec && last_q) begin
      prefix_count_q <= (kind_q == KIND_QUERY && !stop_n) ?
                        PREFIX_COUNT_W'(count_n) : '0;
      status_q       <= (kind_q == KIND_INSERT && stop_n) ?
                        STATUS_POOL_FULL : STATUS_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      cursor_q    <= '0;
      stopped_q   <= 1'b0;
      used_q      <= UsedW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) clr_cnt_q <= clr_cnt_q + NodeW'(1);
      if (cmd_i.exec) begin
        if (last_q) begin
          cursor_q  <= '0;
          stopped_q <= 1'b0;
        end else begin
          cursor_q  <= cursor_n;
          stopped_q <= stop_n;
        end
        if (alloc_n) used_q <= used_q + UsedW'(1);
      end
      if (cmd_i.exec && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.clear_last = clr_cnt_q == NodeW'(NODE_POOL - 1);
  assign status_o.item_last  = last_q;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign prefix_count_o = prefix_count_q;
  assign res_status_o   = status_q;

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != '0 && used_q <= UsedW'(NODE_POOL))
    else $error("node pool fill out of range");

  a_cursor_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    UsedW'(cursor_q) < used_q)
    else $error("cursor on a node not yet taken from the pool");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && last_q |-> !(out_valid_q && !out_ready_i))
    else $error("waiting result overwritten");

endmodule

@@ rtl/trie_prefix_counter_top.sv @@
// Prefix-counting trie over words of letter indices.
// item_i (sink): one beat per letter with kind (insert or query), letter and a
// last flag on the word's final letter. result_o (source): one beat per word,
// on its last letter: prefix_count for a query (0 when a prefix is absent),
// status for an insert (set when the node pool ran out or a letter was past the alphabet). Both use valid/ready.
// For each letter the cursor node's row of child links and child counts is read,
// then the updated row is written back and the cursor moves. The row read depends
// on the previous letter's cursor, so ready is low while a letter executes and a
// new letter is taken only once the previous one is written back. A word's result
// appears in the output register the cycle after its last letter is executed.
// The result register decouples the sides: a letter is still accepted while a
// result waits; only a second word end stalls in execution until the waiting
// result is taken, and ready stays low meanwhile.
// After reset all NODE_POOL rows (4096 by default) of the row memory are swept to
// zero, one row per cycle; ready is low during the sweep.
module trie_prefix_counter_top import tpc_pkg::*; #(
  parameter int unsigned NODE_POOL  = NODE_POOL_DEF,
  parameter int unsigned ALPHABET   = ALPHABET_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tpc_item_if.sink      item_i,
  tpc_result_if.source  result_o
);

  tpc_cmd_t    cmd;
  tpc_status_t status;

  tpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tpc_datapath #(
    .NODE_POOL  (NODE_POOL),
    .ALPHABET   (ALPHABET),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_i         (item_i.kind),
    .letter_i       (item_i.letter),
    .last_i         (item_i.last),
    .out_valid_o    (result_o.valid),
    .out_ready_i    (result_o.ready),
    .prefix_count_o (result_o.prefix_count),
    .res_status_o   (result_o.status)
  );

endmodule

@@ verif/tb_trie_prefix_counter_top.sv @@
`timescale 1ns / 100ps

module tb_trie_prefix_counter_top;
  import tpc_pkg::*;

  localparam int unsigned NODE_W      = $clog2(NODE_POOL_DEF);
  localparam int unsigned MAX_WORD    = 16;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam byte         LETTER_A    = "a";

  typedef struct packed {
    logic [4:0]                         len;
    logic [MAX_WORD-1:0][LETTER_W-1:0] ch;
  } word_t;

  typedef struct packed {
    logic [PREFIX_COUNT_W-1:0] prefix_count;
    logic                      status;
  } word_result_t;

  logic clk;
  logic rst_n;

  tpc_item_if   item_if ();
  tpc_result_if result_if ();

  trie_prefix_counter_top DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if.sink),
    .result_o(result_if.source)
  );

  // Shadow trie
  bit [NODE_W-1:0]         trie_child [NODE_POOL_DEF*ALPHABET_DEF];
  bit [COUNT_BITS_DEF-1:0] node_count [NODE_POOL_DEF];
  bit [NODE_W-1:0]         cursor;
  bit                      walk_dead;
  bit [NODE_W:0]           pool_used = 1;

  word_result_t awaited_word_results[$];
  word_t        inserted_words[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches = 0;
  int unsigned stalled_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void bump_count(bit [NODE_W-1:0] node);
    if (node_count[node] != '1) node_count[node] = node_count[node] + 1'b1;
  endfunction

  // Walks one letter through the shadow trie; queues the word's answer on its last letter
  function automatic void trie_walk_letter(logic kind, logic [LETTER_W-1:0] letter, logic last);
    int unsigned     slot;
    bit [NODE_W-1:0] child;
    word_result_t    res;
    if (!walk_dead) begin
      if (letter >= ALPHABET_DEF) begin
        walk_dead = 1'b1;
      end else begin
        slot  = cursor * ALPHABET_DEF + letter;
        child = trie_child[slot];
        if (kind == KIND_QUERY) begin
          if (child == 0) walk_dead = 1'b1;
          else cursor = child;
        end else begin
          // root is bumped even when the pool then turns out to be full
          if (cursor == 0) bump_count(0);
          if (child == 0) begin
            if (pool_used < NODE_POOL_DEF) begin
              child = pool_used[NODE_W-1:0];
              pool_used++;
              trie_child[slot] = child;
            end else begin
              walk_dead = 1'b1;
            end
          end
          if (!walk_dead) begin
            bump_count(child);
            cursor = child;
          end
        end
      end
    end
    if (last) begin
      if (kind == KIND_QUERY) begin
        res.prefix_count = walk_dead ? '0 : PREFIX_COUNT_W'(node_count[cursor]);
        res.status       = STATUS_DONE;
      end else begin
        res.prefix_count = '0;
        res.status       = walk_dead ? STATUS_POOL_FULL : STATUS_DONE;
      end
      awaited_word_results.push_back(res);
      cursor    = '0;
      walk_dead = 1'b0;
    end
  endfunction

  function automatic word_t make_word(string s);
    word_t w;
    w = '0;
    w.len = 5'(s.len());
    for (int i = 0; i < s.len(); i++) w.ch[i] = LETTER_W'(s[i] - LETTER_A);
    return w;
  endfunction

  function automatic word_t random_word(int unsigned min_len, int unsigned max_len,
                                        int unsigned top_letter);
    word_t w;
    w = '0;
    w.len = 5'($urandom_range(max_len, min_len));
    for (int i = 0; i < w.len; i++) w.ch[i] = LETTER_W'($urandom_range(top_letter));
    return w;
  endfunction

  task automatic send_letter(logic kind, logic [LETTER_W-1:0] letter, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid  <= 1'b1;
    item_if.kind   <= kind;
    item_if.letter <= letter;
    item_if.last   <= last;
    do @(posedge clk); while (!item_if.ready);
    trie_walk_letter(kind, letter, last);
  endtask

  task automatic send_word(logic kind, word_t w);
    for (int i = 0; i < w.len; i++) send_letter(kind, w.ch[i], i == w.len - 1);
  endtask

  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (awaited_word_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_words();
    send_word(KIND_QUERY, make_word("c"));   // nothing inserted yet
    send_word(KIND_INSERT, make_word("a"));
    send_word(KIND_INSERT, make_word("z"));
    send_word(KIND_INSERT, make_word("abc"));
    send_word(KIND_INSERT, make_word("ab"));
    send_word(KIND_QUERY, make_word("a"));
    send_word(KIND_QUERY, make_word("ab"));
    send_word(KIND_QUERY, make_word("abc"));
    send_word(KIND_QUERY, make_word("z"));
    send_word(KIND_QUERY, make_word("b"));   // absent prefix
    // letter past the alphabet in the middle of an insert
    send_letter(KIND_INSERT, 5'd3, 1'b0);
    send_letter(KIND_INSERT, 5'd31, 1'b0);
    send_letter(KIND_INSERT, 5'd4, 1'b1);
    send_word(KIND_QUERY, make_word("d"));
    send_letter(KIND_QUERY, 5'd26, 1'b1);
    // mixed kinds: last letter picks the form of the answer
    send_letter(KIND_QUERY, 5'd0, 1'b0);
    send_letter(KIND_INSERT, 5'd1, 1'b1);
    send_letter(KIND_INSERT, 5'd0, 1'b0);
    send_letter(KIND_QUERY, 5'd1, 1'b1);
  endtask

  task automatic test_random_words(int unsigned n_letters);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    word_t       w;
    sent = 0;
    while (sent < n_letters) begin
      pick = $urandom_range(99);
      if (pick < 45 || inserted_words.size() == 0) begin
        // small alphabet half the time so words share prefixes
        if (inserted_words.size() != 0 && $urandom_range(4) == 0)
          w = inserted_words[$urandom_range(inserted_words.size() - 1)];
        else
          w = random_word(1, 6, $urandom_range(1) ? 3 : ALPHABET_DEF - 1);
        inserted_words.push_back(w);
        send_word(KIND_INSERT, w);
        sent += w.len;
      end else if (pick < 85) begin
        w = inserted_words[$urandom_range(inserted_words.size() - 1)];
        w.len = 5'($urandom_range(w.len, 1));
        if ($urandom_range(9) == 0)
          w.ch[w.len-1] = LETTER_W'($urandom_range(ALPHABET_DEF - 1));
        send_word(KIND_QUERY, w);
        sent += w.len;
      end else begin
        // broken words: mixed kinds, letters past the alphabet
        len = $urandom_range(5, 1);
        for (int i = 0; i < len; i++)
          send_letter(1'($urandom_range(1)), LETTER_W'($urandom_range(31)), i == len - 1);
        sent += len;
      end
      if ($urandom_range(39) == 0) wait_drained();
    end
  endtask

  always @(posedge clk) begin
    word_result_t want;
    if (result_if.valid && result_if.ready) begin
      if (awaited_word_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual count=%0d status=%0b",
                 $time, result_if.prefix_count, result_if.status);
        mismatches++;
      end else begin
        want = awaited_word_results.pop_front();
        if (result_if.prefix_count !== want.prefix_count) begin
          $display("%0t: prefix_count mismatch: expected %0d, actual %0d",
                   $time, want.prefix_count, result_if.prefix_count);
          mismatches++;
        end
        if (result_if.status !== want.status) begin
          $display("%0t: status mismatch: expected %0b, actual %0b",
                   $time, want.status, result_if.status);
          mismatches++;
        end
      end
    end
    result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
  end

  initial begin
    wait (stalled_cycles >= STALL_LIMIT);
    $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    item_if.valid   <= 1'b0;
    item_if.kind    <= KIND_INSERT;
    item_if.letter  <= '0;
    item_if.last    <= 1'b0;
    send_idle_pct   = 18;
    recv_idle_pct   = 45;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_words();
    test_random_words(125);
    wait_drained();
    send_idle_pct = 45;
    recv_idle_pct = 18;
    test_random_words(125);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_words(125);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tpc_pkg.sv
rtl/tpc_item_if.sv
rtl/tpc_result_if.sv
rtl/tpc_ctrl.sv
rtl/tpc_datapath.sv
rtl/trie_prefix_counter_top.sv
verif/tb_trie_prefix_counter_top.sv
